FILE: rtl/core/trace_event_timestamp_decoder_macros.svh
// ----------------------------------------------------------------------------
// Trace event timestamp decoder assertion macros
// Shared forms for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef TRACE_EVENT_TIMESTAMP_DECODER_MACROS_SVH
`define TRACE_EVENT_TIMESTAMP_DECODER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define TSDEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TSDEC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tsdec_pkg.sv
// ----------------------------------------------------------------------------
// Trace event timestamp decoder package
// Transfer types, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package tsdec_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREADS_ONLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THREAD_CLASS = 2'd2;

    localparam logic [31:0] CLOCK_HZ_RESET = 32'd1000000000;

    localparam int NS_W      = 30;
    localparam int MAG_W     = 32;
    localparam int PROD_W    = MAG_W + NS_W;
    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [4:0] CLASS_MASK = 5'h1F;
    localparam logic [9:0] CODE_MASK  = 10'h3FF;
    localparam logic [5:0] CPU_MASK   = 6'h3F;
    localparam logic [1:0] KIND_MASK  = 2'h3;

    typedef struct packed {
        logic [31:0]        event_header;
        logic [31:0]        cycle_count;
        logic [31:0]        word_one;
        logic [31:0]        word_two;
        logic               first_of_buffer;
        logic signed [63:0] base_time_ns;
    } tsdec_in_t;

    typedef struct packed {
        logic signed [63:0] time_ns;
        logic [4:0]         event_class;
        logic [9:0]         event_code;
        logic [5:0]         cpu_number;
        logic [1:0]         struct_kind;
        logic [31:0]        cycle_out;
        logic [31:0]        data_one;
        logic [31:0]        data_two;
    } tsdec_out_t;

    typedef struct packed {
        logic [PROD_W-1:0] quotient;
        logic [DIV_W-1:0]  remainder;
        logic              done;
    } tsdec_div_rsp_t;

endpackage

FILE: rtl/core/tsdec_div.sv
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Divides the scaled cycle delta by the clock frequency, one bit per cycle.
// ----------------------------------------------------------------------------
module tsdec_div
    import tsdec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output tsdec_div_rsp_t    rsp
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_CNT_W-1:0] count_next;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [PROD_W-1:0]    quot_reg;
    logic [PROD_W-1:0]    quot_next;
    logic [DIV_W-1:0]     divisor_reg;
    logic [DIV_W-1:0]     divisor_next;
    logic [DIV_W:0]       shifted;
    logic                 fits;

    assign shifted = {rem_reg, quot_reg[PROD_W-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quot_next    = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? DIV_W'(shifted - {1'b0, divisor_reg}) : shifted[DIV_W-1:0];
            quot_next  = {quot_reg[PROD_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;
    assign rsp.done      = done_reg;

endmodule

FILE: rtl/core/trace_event_timestamp_decoder.sv
// ----------------------------------------------------------------------------
// Trace event timestamp decoder
// Rebuilds event times in ns from cycle counts and splits the header word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                              Transfer when
//  event     in         event_valid/ready, event_data        valid & ready
//  result    out        result_valid/ready, result_data      valid & ready
//  cfg       in         cfg_valid/ready, cfg_index, cfg_data valid & ready
//
// An event that starts a buffer, or arrives while clock_hz is zero, goes
// from IDLE straight to DONE, where a kept result is loaded. Any other
// event runs MUL, the 62 divider steps in DIV, then ADD. The block takes no
// event while one is in flight; a held result stalls only the final step.
// Reset needs no clearing pass; cfg_ready is always high.
// ----------------------------------------------------------------------------
module trace_event_timestamp_decoder
    import tsdec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 event_valid,
    output logic                 event_ready,
    input  tsdec_in_t            event_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output tsdec_out_t           result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [31:0]       clock_hz_reg;
    logic              threads_only_reg;
    logic [4:0]        thread_class_reg;
    logic [31:0]       last_cycle_reg;
    logic [31:0]       last_cycle_next;
    logic [63:0]       last_time_reg;
    logic [63:0]       last_time_next;
    tsdec_in_t         item_reg;
    tsdec_in_t         item_next;
    logic              keep_reg;
    logic              keep_next;
    logic              neg_reg;
    logic              neg_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic [63:0]       scaled_reg;
    logic [63:0]       scaled_next;
    logic [63:0]       time_reg;
    logic [63:0]       time_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    tsdec_out_t        result_reg;
    tsdec_out_t        result_next;
    logic              accept;
    logic [31:0]       delta;
    logic [4:0]        in_class;
    logic [PROD_W-1:0] product;
    logic [63:0]       quot_ext;
    logic              div_start;
    tsdec_div_rsp_t    div_rsp;

    assign event_ready  = (state_reg == ST_IDLE);
    assign accept       = event_valid && event_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    assign delta    = event_data.cycle_count - last_cycle_reg;
    assign in_class = (event_data.event_header[14:10]) & CLASS_MASK;
    assign product  = PROD_W'(mag_reg) * PROD_W'(NS_PER_SEC);
    assign quot_ext = {{(64 - PROD_W){1'b0}}, div_rsp.quotient};
    assign div_start = (state_reg == ST_MUL);

    tsdec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (clock_hz_reg),
        .rsp      (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg     <= CLOCK_HZ_RESET;
            threads_only_reg <= 1'b0;
            thread_class_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLOCK_HZ:     clock_hz_reg     <= cfg_data;
                CFG_THREADS_ONLY: threads_only_reg <= cfg_data[0];
                CFG_THREAD_CLASS: thread_class_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        last_cycle_next   = last_cycle_reg;
        last_time_next    = last_time_reg;
        item_next         = item_reg;
        keep_next         = keep_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        scaled_next       = scaled_reg;
        time_next         = time_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next       = event_data;
                    keep_next       = !threads_only_reg || (in_class == thread_class_reg);
                    last_cycle_next = event_data.cycle_count;
                    neg_next        = delta[31];
                    mag_next        = delta[31] ? (~delta + 32'd1) : delta;
                    if (event_data.first_of_buffer)
                    begin
                        time_next  = event_data.base_time_ns;
                        state_next = ST_DONE;
                    end
                    else if (clock_hz_reg == '0)
                    begin
                        time_next  = last_time_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (neg_reg)
                    begin
                        scaled_next = ~quot_ext + 64'(div_rsp.remainder == '0);
                    end
                    else
                    begin
                        scaled_next = quot_ext;
                    end
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                time_next  = last_time_reg + scaled_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                last_time_next = time_reg;
                if (!keep_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!result_valid_reg || result_ready)
                begin
                    result_valid_next       = 1'b1;
                    result_next.time_ns     = time_reg;
                    result_next.event_class = item_reg.event_header[14:10] & CLASS_MASK;
                    result_next.event_code  = item_reg.event_header[9:0] & CODE_MASK;
                    result_next.cpu_number  = item_reg.event_header[29:24] & CPU_MASK;
                    result_next.struct_kind = item_reg.event_header[31:30] & KIND_MASK;
                    result_next.cycle_out   = item_reg.cycle_count;
                    result_next.data_one    = item_reg.word_one;
                    result_next.data_two    = item_reg.word_two;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            last_cycle_reg   <= '0;
            last_time_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_cycle_reg   <= last_cycle_next;
            last_time_reg    <= last_time_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        keep_reg   <= keep_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        scaled_reg <= scaled_next;
        time_reg   <= time_next;
        result_reg <= result_next;
    end

endmodule

FILE: rtl/core/tsdec_checker.sv
// ----------------------------------------------------------------------------
// Trace event timestamp decoder checker
// Port-level checks on transfer order and result holding.
// ----------------------------------------------------------------------------
`include "trace_event_timestamp_decoder_macros.svh"

module tsdec_checker
    import tsdec_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 event_valid,
    input logic                 event_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input tsdec_out_t           result_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    logic event_xfer;
    logic result_stall;

    assign event_xfer   = event_valid && event_ready;
    assign result_stall = result_valid && !result_ready;

    // A held result keeps its contents until the transfer completes.
    `TSDEC_ASSERT_NEXT(a_result_hold, result_stall,
        result_valid && $stable(result_data), "result changed while stalled")

    // The block is busy in the cycle after taking an event.
    `TSDEC_ASSERT_NEXT(a_busy_after_xfer, event_xfer, !event_ready, "event taken back to back")

    // A new result never appears in the cycle right after an event transfer.
    `TSDEC_ASSERT_SAME(a_result_latency, $rose(result_valid), !$past(event_xfer),
        "result too early")

    // The configuration port never stalls.
    `TSDEC_ASSERT_NEXT(a_cfg_ready, cfg_valid, cfg_ready, "configuration port stalled")

endmodule

bind trace_event_timestamp_decoder tsdec_checker u_tsdec_checker (.*);
